>>> design/tle_pkg.sv
// Shared types, character codes and widths for the terminal line editor.
`default_nettype none

package tle_pkg;

    localparam int C_LINE_DEPTH = 64;
    localparam int W_EVENT      = 4;
    localparam int W_CHAR       = 8;
    localparam int W_POS        = 6;

    localparam logic [7:0] C_ESC       = 8'h1b;
    localparam logic [7:0] C_DEL       = 8'h7f;
    localparam logic [7:0] C_TILDE     = 8'h7e;
    localparam logic [7:0] C_CTL_MASK  = 8'h1f;
    localparam logic [7:0] C_CR        = 8'h0d;
    localparam logic [7:0] C_LF        = 8'h0a;
    localparam logic [7:0] C_SPACE     = 8'h20;
    localparam logic [7:0] C_LBRACKET  = 8'h5b;
    localparam logic [7:0] C_LETTER_O  = 8'h4f;
    localparam logic [7:0] C_LETTER_A  = 8'h41;
    localparam logic [7:0] C_LETTER_B  = 8'h42;
    localparam logic [7:0] C_LETTER_C  = 8'h43;
    localparam logic [7:0] C_LETTER_D  = 8'h44;
    localparam logic [7:0] C_LETTER_E  = 8'h45;
    localparam logic [7:0] C_LETTER_F  = 8'h46;
    localparam logic [7:0] C_LETTER_H  = 8'h48;
    localparam logic [7:0] C_LETTER_L  = 8'h4c;
    localparam logic [7:0] C_DIGIT_0   = 8'h30;
    localparam logic [7:0] C_DIGIT_1   = 8'h31;
    localparam logic [7:0] C_DIGIT_3   = 8'h33;
    localparam logic [7:0] C_DIGIT_4   = 8'h34;
    localparam logic [7:0] C_DIGIT_7   = 8'h37;
    localparam logic [7:0] C_DIGIT_8   = 8'h38;
    localparam logic [7:0] C_DIGIT_9   = 8'h39;

    localparam logic [7:0] C_CTL_A = C_LETTER_A & C_CTL_MASK;
    localparam logic [7:0] C_CTL_B = C_LETTER_B & C_CTL_MASK;
    localparam logic [7:0] C_CTL_C = C_LETTER_C & C_CTL_MASK;
    localparam logic [7:0] C_CTL_E = C_LETTER_E & C_CTL_MASK;
    localparam logic [7:0] C_CTL_F = C_LETTER_F & C_CTL_MASK;
    localparam logic [7:0] C_CTL_L = C_LETTER_L & C_CTL_MASK;

    typedef enum logic [W_EVENT-1:0] {
        EV_NONE      = 4'd0,
        EV_MOVE      = 4'd1,
        EV_TEXT      = 4'd2,
        EV_REDRAW    = 4'd3,
        EV_HIST_UP   = 4'd4,
        EV_HIST_DOWN = 4'd5,
        EV_CHAR      = 4'd6,
        EV_DONE      = 4'd7,
        EV_CANCEL    = 4'd8,
        EV_FULL      = 4'd9
    } t_event;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_1,
        ESC_2,
        ESC_TILDE
    } t_esc;

    typedef enum logic [3:0] {
        K_NONE,
        K_UP,
        K_DOWN,
        K_LEFT,
        K_RIGHT,
        K_HOME,
        K_END,
        K_DELETE,
        K_BKSP,
        K_ENTER,
        K_CANCEL,
        K_REDRAW,
        K_INSERT
    } t_key;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SH_RD,
        S_SH_WR,
        S_PUT,
        S_EM_CHECK,
        S_EM_OUT,
        S_RESULT
    } t_state;

    typedef struct packed {
        t_esc esc_next;
        t_key key;
    } t_dec;

    typedef struct packed {
        logic               valid;
        t_event             event_res;
        logic [W_CHAR-1:0]  line_char;
        logic [W_POS-1:0]   cursor_pos;
        logic [W_POS-1:0]   line_length;
        logic               last;
    } t_res;

endpackage

`default_nettype wire

>>> design/terminal_line_editor.sv
// Top level of the terminal line editor with its output register.
//
// Input channel: one terminal byte per beat on i_in_byte, taken when i_in_valid
// is high and o_in_stall is low. The block takes one byte at a time and holds
// o_in_stall high until the last result of that byte has entered the output
// register.
// Output channel: one result per beat, presented on o_out_valid and held while
// i_out_stall is high. Every byte gives at least one result; o_last marks the
// final one. An output register parts the channels, so the next byte is taken
// while the last result still waits.
// Sequence: a byte that moves no text goes from S_IDLE through S_RESULT into
// the output register. An insert or delete shifts the line store one entry
// per S_SH_RD and S_SH_WR pair, through its one read port and one write port.
// Enter reads the line one character per S_EM_CHECK and S_EM_OUT pair, and
// S_EM_OUT waits while the receiver stalls.
// Reset clears the escape decoder, the cursor, the line length and the output
// valid; the line store keeps whatever it held and needs no clearing.
`default_nettype none

module terminal_line_editor #(
    parameter int LINE_DEPTH = tle_pkg::C_LINE_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [7:0]                    i_in_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [tle_pkg::W_EVENT-1:0]        o_event_res,
    output logic [tle_pkg::W_CHAR-1:0]         o_line_char,
    output logic [tle_pkg::W_POS-1:0]          o_cursor_pos,
    output logic [tle_pkg::W_POS-1:0]          o_line_length,
    output logic                               o_last
);

    tle_pkg::t_res res;
    logic          res_ready;
    logic          r_out_valid;
    tle_pkg::t_res r_out;

    tle_seq #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_byte   (i_in_byte),
        .o_in_stall  (o_in_stall),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
        if (res_ready && res.valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_res   = r_out.event_res;
    assign o_line_char   = r_out.line_char;
    assign o_cursor_pos  = r_out.cursor_pos;
    assign o_line_length = r_out.line_length;
    assign o_last        = r_out.last;

endmodule

`default_nettype wire

>>> design/tle_mem.sv
// Line store: one write port and one registered read port.
`default_nettype none

module tle_mem #(
    parameter int DEPTH = tle_pkg::C_LINE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [AW-1:0]               i_waddr,
    input  wire logic [tle_pkg::W_CHAR-1:0]  i_wdata,
    input  wire logic [AW-1:0]               i_raddr,
    output logic      [tle_pkg::W_CHAR-1:0]  o_rdata
);

    logic [tle_pkg::W_CHAR-1:0] r_mem [DEPTH];
    logic [tle_pkg::W_CHAR-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/tle_dec.sv
// Escape sequence and control byte decoder for the line editor.
`default_nettype none

module tle_dec (
    input  wire logic [7:0]    i_byte,
    input  wire tle_pkg::t_esc i_esc,
    input  wire logic [7:0]    i_first,
    input  wire logic [7:0]    i_second,
    output tle_pkg::t_dec      o_dec
);

    function automatic tle_pkg::t_key decode_two(input logic [7:0] first,
                                                 input logic [7:0] second);
        tle_pkg::t_key key;
        key = tle_pkg::K_NONE;
        if (first == tle_pkg::C_LBRACKET) begin
            unique case (second)
                tle_pkg::C_LETTER_A: key = tle_pkg::K_UP;
                tle_pkg::C_LETTER_B: key = tle_pkg::K_DOWN;
                tle_pkg::C_LETTER_C: key = tle_pkg::K_RIGHT;
                tle_pkg::C_LETTER_D: key = tle_pkg::K_LEFT;
                tle_pkg::C_LETTER_H: key = tle_pkg::K_HOME;
                tle_pkg::C_LETTER_F: key = tle_pkg::K_END;
                default:             key = tle_pkg::K_NONE;
            endcase
        end else if (first == tle_pkg::C_LETTER_O) begin
            if (second == tle_pkg::C_LETTER_H) begin
                key = tle_pkg::K_HOME;
            end else if (second == tle_pkg::C_LETTER_F) begin
                key = tle_pkg::K_END;
            end
        end
        return key;
    endfunction

    function automatic tle_pkg::t_key decode_tilde(input logic [7:0] second);
        tle_pkg::t_key key;
        unique case (second) inside
            tle_pkg::C_DIGIT_1, tle_pkg::C_DIGIT_7: key = tle_pkg::K_HOME;
            tle_pkg::C_DIGIT_4, tle_pkg::C_DIGIT_8: key = tle_pkg::K_END;
            tle_pkg::C_DIGIT_3:                     key = tle_pkg::K_DELETE;
            default:                                key = tle_pkg::K_NONE;
        endcase
        return key;
    endfunction

    function automatic tle_pkg::t_key decode_char(input logic [7:0] b);
        tle_pkg::t_key key;
        unique case (b) inside
            tle_pkg::C_CR, tle_pkg::C_LF: key = tle_pkg::K_ENTER;
            tle_pkg::C_CTL_A:             key = tle_pkg::K_HOME;
            tle_pkg::C_CTL_E:             key = tle_pkg::K_END;
            tle_pkg::C_CTL_B:             key = tle_pkg::K_LEFT;
            tle_pkg::C_CTL_F:             key = tle_pkg::K_RIGHT;
            tle_pkg::C_CTL_C:             key = tle_pkg::K_CANCEL;
            tle_pkg::C_CTL_L:             key = tle_pkg::K_REDRAW;
            tle_pkg::C_DEL:               key = tle_pkg::K_BKSP;
            default: begin
                if (b < tle_pkg::C_SPACE || b > tle_pkg::C_TILDE) begin
                    key = tle_pkg::K_NONE;
                end else begin
                    key = tle_pkg::K_INSERT;
                end
            end
        endcase
        return key;
    endfunction

    always_comb begin
        o_dec.esc_next = tle_pkg::ESC_IDLE;
        o_dec.key      = tle_pkg::K_NONE;
        unique case (i_esc)
            tle_pkg::ESC_1: begin
                o_dec.esc_next = tle_pkg::ESC_2;
            end
            tle_pkg::ESC_2: begin
                if (i_first == tle_pkg::C_LBRACKET && i_byte >= tle_pkg::C_DIGIT_0
                        && i_byte <= tle_pkg::C_DIGIT_9) begin
                    o_dec.esc_next = tle_pkg::ESC_TILDE;
                end else begin
                    o_dec.key = decode_two(i_first, i_byte);
                end
            end
            tle_pkg::ESC_TILDE: begin
                if (i_byte == tle_pkg::C_TILDE) begin
                    o_dec.key = decode_tilde(i_second);
                end
            end
            default: begin
                if (i_byte == tle_pkg::C_ESC) begin
                    o_dec.esc_next = tle_pkg::ESC_1;
                end else begin
                    o_dec.key = decode_char(i_byte);
                end
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/tle_seq.sv
// Editing sequencer: shifts, inserts and streams the line through the store one entry at a time.
`default_nettype none

module tle_seq #(
    parameter int LINE_DEPTH = tle_pkg::C_LINE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_in_stall,
    output tle_pkg::t_res    o_res,
    input  wire logic        i_res_ready
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam logic [AW-1:0] LMAX = AW'(LINE_DEPTH - 1);
    localparam logic [AW:0]   ONE_W = (AW+1)'(1);

    tle_pkg::t_state r_state, n_state;
    tle_pkg::t_esc   r_esc, n_esc;
    tle_pkg::t_event r_event, n_event;
    logic [7:0]      r_first, n_first;
    logic [7:0]      r_second, n_second;
    logic [7:0]      r_byte, n_byte;
    logic [AW-1:0]   r_cursor, n_cursor;
    logic [AW-1:0]   r_len, n_len;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic            r_ins, n_ins;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [tle_pkg::W_CHAR-1:0]  mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic [tle_pkg::W_CHAR-1:0]  mem_rdata;
    logic [AW-1:0]               step_ptr;
    tle_pkg::t_dec               dec;

    tle_dec u_dec (
        .i_byte   (i_in_byte),
        .i_esc    (r_esc),
        .i_first  (r_first),
        .i_second (r_second),
        .o_dec    (dec)
    );

    tle_mem #(
        .DEPTH (LINE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tle_pkg::S_IDLE;
            r_esc    <= tle_pkg::ESC_IDLE;
            r_first  <= '0;
            r_second <= '0;
            r_cursor <= '0;
            r_len    <= '0;
        end else begin
            r_state  <= n_state;
            r_esc    <= n_esc;
            r_first  <= n_first;
            r_second <= n_second;
            r_cursor <= n_cursor;
            r_len    <= n_len;
        end
        r_event <= n_event;
        r_byte  <= n_byte;
        r_ptr   <= n_ptr;
        r_cnt   <= n_cnt;
        r_ins   <= n_ins;
    end

    assign step_ptr = r_ins ? (r_ptr - AW'(1)) : (r_ptr + AW'(1));

    always_comb begin
        n_state   = r_state;
        n_esc     = r_esc;
        n_event   = r_event;
        n_first   = r_first;
        n_second  = r_second;
        n_byte    = r_byte;
        n_cursor  = r_cursor;
        n_len     = r_len;
        n_ptr     = r_ptr;
        n_cnt     = r_cnt;
        n_ins     = r_ins;
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = mem_rdata;
        mem_raddr = r_ptr;
        o_in_stall        = 1'b1;
        o_res.valid       = 1'b0;
        o_res.event_res   = r_event;
        o_res.line_char   = '0;
        o_res.cursor_pos  = tle_pkg::W_POS'(r_cursor);
        o_res.line_length = tle_pkg::W_POS'(r_len);
        o_res.last        = 1'b1;

        unique case (r_state)
            tle_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_esc   = dec.esc_next;
                    n_event = tle_pkg::EV_NONE;
                    n_state = tle_pkg::S_RESULT;
                    if (r_esc == tle_pkg::ESC_1) begin
                        n_first = i_in_byte;
                    end
                    if (r_esc == tle_pkg::ESC_2) begin
                        n_second = i_in_byte;
                    end
                    unique case (dec.key)
                        tle_pkg::K_UP:     n_event = tle_pkg::EV_HIST_UP;
                        tle_pkg::K_DOWN:   n_event = tle_pkg::EV_HIST_DOWN;
                        tle_pkg::K_REDRAW: n_event = tle_pkg::EV_REDRAW;
                        tle_pkg::K_LEFT: begin
                            if (r_cursor != '0) begin
                                n_cursor = r_cursor - AW'(1);
                                n_event  = tle_pkg::EV_MOVE;
                            end
                        end
                        tle_pkg::K_RIGHT: begin
                            if (r_cursor < r_len) begin
                                n_cursor = r_cursor + AW'(1);
                                n_event  = tle_pkg::EV_MOVE;
                            end
                        end
                        tle_pkg::K_HOME: begin
                            n_cursor = '0;
                            n_event  = tle_pkg::EV_MOVE;
                        end
                        tle_pkg::K_END: begin
                            n_cursor = r_len;
                            n_event  = tle_pkg::EV_MOVE;
                        end
                        tle_pkg::K_CANCEL: begin
                            n_cursor = '0;
                            n_len    = '0;
                            n_event  = tle_pkg::EV_CANCEL;
                        end
                        tle_pkg::K_DELETE: begin
                            if (r_cursor < r_len) begin
                                n_ins   = 1'b0;
                                n_ptr   = r_cursor;
                                n_event = tle_pkg::EV_TEXT;
                                if ({1'b0, r_cursor} + ONE_W < {1'b0, r_len}) begin
                                    n_state = tle_pkg::S_SH_RD;
                                end else begin
                                    n_len = r_len - AW'(1);
                                end
                            end
                        end
                        tle_pkg::K_BKSP: begin
                            if (r_cursor != '0) begin
                                n_ins    = 1'b0;
                                n_ptr    = r_cursor - AW'(1);
                                n_cursor = r_cursor - AW'(1);
                                n_event  = tle_pkg::EV_TEXT;
                                if (r_cursor < r_len) begin
                                    n_state = tle_pkg::S_SH_RD;
                                end else begin
                                    n_len = r_len - AW'(1);
                                end
                            end
                        end
                        tle_pkg::K_ENTER: begin
                            n_ptr    = '0;
                            n_cnt    = r_len;
                            n_len    = '0;
                            n_cursor = '0;
                            n_state  = tle_pkg::S_EM_CHECK;
                        end
                        tle_pkg::K_INSERT: begin
                            if (r_len >= LMAX) begin
                                n_event = tle_pkg::EV_FULL;
                            end else begin
                                n_ins  = 1'b1;
                                n_byte = i_in_byte;
                                n_ptr  = r_len;
                                if (r_len > r_cursor) begin
                                    n_state = tle_pkg::S_SH_RD;
                                end else begin
                                    n_state = tle_pkg::S_PUT;
                                end
                            end
                        end
                        default: n_event = tle_pkg::EV_NONE;
                    endcase
                end
            end
            tle_pkg::S_SH_RD: begin
                mem_raddr = step_ptr;
                n_state   = tle_pkg::S_SH_WR;
            end
            tle_pkg::S_SH_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = mem_rdata;
                n_ptr     = step_ptr;
                if (r_ins) begin
                    if (step_ptr > r_cursor) begin
                        n_state = tle_pkg::S_SH_RD;
                    end else begin
                        n_state = tle_pkg::S_PUT;
                    end
                end else begin
                    if ({1'b0, step_ptr} + ONE_W < {1'b0, r_len}) begin
                        n_state = tle_pkg::S_SH_RD;
                    end else begin
                        n_len   = r_len - AW'(1);
                        n_event = tle_pkg::EV_TEXT;
                        n_state = tle_pkg::S_RESULT;
                    end
                end
            end
            tle_pkg::S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_cursor;
                mem_wdata = r_byte;
                n_cursor  = r_cursor + AW'(1);
                n_len     = r_len + AW'(1);
                n_event   = tle_pkg::EV_TEXT;
                n_state   = tle_pkg::S_RESULT;
            end
            tle_pkg::S_EM_CHECK: begin
                if (r_ptr < r_cnt) begin
                    n_state = tle_pkg::S_EM_OUT;
                end else begin
                    n_event = tle_pkg::EV_DONE;
                    n_state = tle_pkg::S_RESULT;
                end
            end
            tle_pkg::S_EM_OUT: begin
                o_res.valid     = 1'b1;
                o_res.event_res = tle_pkg::EV_CHAR;
                o_res.line_char = mem_rdata;
                o_res.last      = 1'b0;
                if (i_res_ready) begin
                    n_ptr   = r_ptr + AW'(1);
                    n_state = tle_pkg::S_EM_CHECK;
                end
            end
            tle_pkg::S_RESULT: begin
                o_res.valid = 1'b1;
                if (i_res_ready) begin
                    n_state = tle_pkg::S_IDLE;
                end
            end
            default: n_state = tle_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> design/tle_checker.sv
// Port-level checker for the terminal line editor and its bind.
`default_nettype none

module tle_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire logic [7:0]                     i_in_byte,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire logic [tle_pkg::W_EVENT-1:0]    o_event_res,
    input wire logic [tle_pkg::W_CHAR-1:0]     o_line_char,
    input wire logic [tle_pkg::W_POS-1:0]      o_cursor_pos,
    input wire logic [tle_pkg::W_POS-1:0]      o_line_length,
    input wire logic                           o_last
);

    logic unused_in;
    assign unused_in = i_in_valid ^ o_in_stall ^ (^i_in_byte);

    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_event_res <= tle_pkg::EV_FULL)
        else $error("Result event code out of range.");

    a_char_only_on_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res != tle_pkg::EV_CHAR) |-> o_line_char == '0)
        else $error("Line character set on a result that is not a line character.");

    a_commit_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res == tle_pkg::EV_CHAR || o_event_res == tle_pkg::EV_DONE))
        |-> (o_cursor_pos == '0 && o_line_length == '0
             && o_last == (o_event_res == tle_pkg::EV_DONE)))
        else $error("Committed line results carry a wrong cursor, length or last flag.");

    a_cursor_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cursor_pos <= o_line_length)
        else $error("Cursor lies beyond the end of the line.");

    a_stalled_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_event_res)
            && $stable(o_line_char) && $stable(o_last)))
        else $error("Stalled result beat changed.");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (.*);

`default_nettype wire
